// ----- rtl/tnac_pkg.sv -----
// Shared constants for the triangle normal, area and centroid pipeline.
// No dependencies.
`default_nettype none
package tnac_pkg;

  localparam int TAG_BITS       = 16;
  localparam int UNIT_FRAC      = 16;
  localparam int UNIT_BITS      = 18;
  localparam int AREA_BITS      = 50;
  localparam int MANT_BITS      = 31;
  localparam int SQ_BITS        = 2 * MANT_BITS + 2;
  localparam int LEN_BITS       = SQ_BITS / 2;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

endpackage
`default_nettype wire

// ----- rtl/tnac_delay.sv -----
// Enabled shift line that keeps side data aligned with the arithmetic stages.
// No dependencies.
`default_nettype none
module tnac_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] dl_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign dout = dl_r[DEPTH-1];

endmodule
`default_nettype wire

// ----- rtl/tnac_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// No dependencies.
`default_nettype none
module tnac_sqrt #(
  parameter int IN_W = 64,
  localparam int R_W = IN_W / 2
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [IN_W-1:0] din,
  output logic      [R_W-1:0]  root
);

  logic [IN_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]  root_r [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_st
    localparam int B = R_W - 1 - j;
    logic [IN_W-1:0] rem_i;
    logic [R_W-1:0]  root_i;
    logic [IN_W:0]   trial;

    if (j == 0) begin : g_first
      assign rem_i  = din;
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
    end

    assign trial = ((IN_W+1)'(root_i) << (B + 1)) | ((IN_W+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_i} >= trial) begin
          rem_r[j]  <= rem_i - IN_W'(trial);
          root_r[j] <= root_i | (R_W'(1) << B);
        end else begin
          rem_r[j]  <= rem_i;
          root_r[j] <= root_i;
        end
      end
    end
  end

  assign root = root_r[R_W-1];

endmodule
`default_nettype wire

// ----- rtl/tnac_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in Q_W bits. No dependencies.
`default_nettype none
module tnac_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33,
  parameter int Q_W   = 17
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);

  localparam int WW = DEN_W + Q_W;

  logic [WW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_st
    localparam int B = Q_W - 1 - j;
    logic [WW-1:0]    rem_i;
    logic [WW-1:0]    trial;
    logic [DEN_W-1:0] den_i;
    logic [Q_W-1:0]   quo_i;

    if (j == 0) begin : g_first
      assign rem_i = WW'(num);
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[j-1];
      assign den_i = den_r[j-1];
      assign quo_i = quo_r[j-1];
    end

    assign trial = WW'(den_i) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j] <= den_i;
        if (rem_i >= trial) begin
          rem_r[j] <= rem_i - trial;
          quo_r[j] <= quo_i | (Q_W'(1) << B);
        end else begin
          rem_r[j] <= rem_i;
          quo_r[j] <= quo_i;
        end
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule
`default_nettype wire

// ----- rtl/triangle_normal_area_centroid.sv -----
// Triangle face normal, area and centroid: top level pipeline.
// Depends on tnac_pkg, tnac_delay, tnac_sqrt, tnac_div.
//
//   channel | dir | handshake            | payload
//   cfg     | in  | cfg_wr_en            | cfg_wr_data: keep_file_winding
//   in      | in  | in_tvalid/in_tready  | in_tdata: tag, A, B, C
//   out     | out | out_tvalid/out_tready| out_tdata: tag, unit, area, centroid; tuser
//
// One transaction per cycle while no waiting result holds the pipe; the delay is set
// mostly by the 32-stage square root followed by the 17-stage normal divider.
// rst_n (synchronous, low) clears all valid bits, the skid entry and the winding bit.
// A waiting result holds the whole pipe; one input transaction is still taken into
// the skid entry, so no transaction is lost or repeated.
`default_nettype none
module triangle_normal_area_centroid #(
  parameter int COORD_BITS = tnac_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tnac_pkg::FRAC_BITS_DEF,
  localparam int IN_BITS   = tnac_pkg::TAG_BITS + 9 * COORD_BITS,
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = tnac_pkg::TAG_BITS + 3 * tnac_pkg::UNIT_BITS
                             + tnac_pkg::AREA_BITS + 3 * COORD_BITS,
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,  // keep_file_winding
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // face_tag, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  wire logic [IN_TDW-1:0]  in_tdata,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // out_tag, unit_x, unit_y, unit_z, tri_area, mid_x, mid_y, mid_z
  output logic      [OUT_TDW-1:0] out_tdata,
  output logic                    out_tuser     // degenerate
);

  localparam int TAGW  = tnac_pkg::TAG_BITS;
  localparam int MANT  = tnac_pkg::MANT_BITS;
  localparam int UB    = tnac_pkg::UNIT_BITS;
  localparam int AB    = tnac_pkg::AREA_BITS;
  localparam int LENW  = tnac_pkg::LEN_BITS;
  localparam int SQW   = tnac_pkg::SQ_BITS;
  localparam int C     = COORD_BITS;
  localparam int DW    = C + 1;
  localparam int PW    = 2 * DW;
  localparam int NW    = PW + 1;
  localparam int MW    = NW - 1;
  localparam int KW    = $clog2(MW + 1);
  localparam int SW    = C + 2;
  localparam int NUMW  = MANT + tnac_pkg::UNIT_FRAC + 2;
  localparam int DENW  = LENW + 1;
  localparam int UQW   = tnac_pkg::UNIT_FRAC + 1;
  localparam int CQW   = C + 1;
  localparam logic [AB-1:0] AREA_MAX = '1;
  // divide by three: x * ceil(2^TSH / 3) >> TSH, exact for x < 2^TSH with TSH odd
  localparam int TSH   = (C % 2 == 0) ? C + 1 : C + 2;
  localparam int QPW   = SW + TSH;
  localparam logic [TSH-1:0] TRCP = TSH'(((128'd1 << TSH) + 128'd1) / 128'd3);

  localparam int T_IN  = 1;
  localparam int T_DIF = 2;
  localparam int T_S   = 6;
  localparam int T_SUM = 8;
  localparam int T_LEN = T_SUM + LENW;
  localparam int T_SET = T_LEN + 1;
  localparam int T_Q   = T_SET + UQW;
  localparam int T_OUT = T_Q + 1;

  // Flow control and skid entry
  logic              adv;
  logic              in_fire;
  logic              skid_v_r;
  logic [IN_TDW-1:0] skid_r;
  logic              pv;
  logic [IN_TDW-1:0] pdata;
  logic              kfw_r;
  logic              vld_r [T_OUT];

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign pv        = skid_v_r || in_fire;
  assign pdata     = skid_v_r ? skid_r : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (in_fire && !adv) begin
      skid_v_r <= 1'b1;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !adv) begin
      skid_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kfw_r <= 1'b0;
    end else if (cfg_wr_en) begin
      kfw_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < T_OUT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= pv;
      for (int i = 1; i < T_OUT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: vertices, winding applied
  logic [TAGW-1:0]     tag1_r;
  logic signed [C-1:0] a1_r [3];
  logic signed [C-1:0] b1_r [3];
  logic signed [C-1:0] c1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= pdata[TAGW-1:0];
      for (int i = 0; i < 3; i++) begin
        a1_r[i] <= pdata[TAGW + i*C +: C];
        if (kfw_r) begin
          b1_r[i] <= pdata[TAGW + (3+i)*C +: C];
          c1_r[i] <= pdata[TAGW + (6+i)*C +: C];
        end else begin
          b1_r[i] <= pdata[TAGW + (6+i)*C +: C];
          c1_r[i] <= pdata[TAGW + (3+i)*C +: C];
        end
      end
    end
  end

  // Stage 2: edges and coordinate sums
  logic signed [DW-1:0] u2_r [3];
  logic signed [DW-1:0] v2_r [3];
  logic [SW-1:0]        cm2_r [3];
  logic                 cs2_r [3];
  logic signed [SW-1:0] csum_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum_nxt[i] = SW'(a1_r[i]) + SW'(b1_r[i]) + SW'(c1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u2_r[i]  <= DW'(b1_r[i]) - DW'(a1_r[i]);
        v2_r[i]  <= DW'(c1_r[i]) - DW'(a1_r[i]);
        cs2_r[i] <= csum_nxt[i][SW-1];
        cm2_r[i] <= (csum_nxt[i][SW-1] ? SW'(0) - csum_nxt[i] : csum_nxt[i]) + SW'(1);
      end
    end
  end

  // Stage 3: partial products of the cross product
  logic signed [PW-1:0] p3_r [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r[0] <= u2_r[1] * v2_r[2];
      p3_r[1] <= u2_r[2] * v2_r[1];
      p3_r[2] <= u2_r[2] * v2_r[0];
      p3_r[3] <= u2_r[0] * v2_r[2];
      p3_r[4] <= u2_r[0] * v2_r[1];
      p3_r[5] <= u2_r[1] * v2_r[0];
    end
  end

  // Stage 4: cross product, sign and magnitude
  logic signed [NW-1:0] n_nxt [3];
  logic [MW-1:0]        m4_r  [3];
  logic                 ng4_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = NW'(p3_r[2*i]) - NW'(p3_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ng4_r[i] <= n_nxt[i][NW-1];
        m4_r[i]  <= MW'(n_nxt[i][NW-1] ? NW'(0) - n_nxt[i] : n_nxt[i]);
      end
    end
  end

  // Stage 5: normalising shift
  logic [MW-1:0] orv;
  logic [KW-1:0] bl_nxt;
  logic [MW-1:0] m5_r  [3];
  logic          ng5_r [3];
  logic [KW-1:0] k5_r;

  assign orv = m4_r[0] | m4_r[1] | m4_r[2];

  always_comb begin
    bl_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) bl_nxt = KW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_r  <= m4_r;
      ng5_r <= ng4_r;
      k5_r  <= (bl_nxt > KW'(MANT)) ? bl_nxt - KW'(MANT) : '0;
    end
  end

  // Stage 6: reduced components
  logic [MANT-1:0] s6_r  [3];
  logic            ng6_r [3];
  logic [KW-1:0]   k6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s6_r[i] <= MANT'(m5_r[i] >> k5_r);
      ng6_r <= ng5_r;
      k6_r  <= k5_r;
    end
  end

  // Stages 7 and 8: squared length
  logic [2*MANT-1:0] sq7_r [3];
  logic [SQW-1:0]    sum8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq7_r[i] <= s6_r[i] * s6_r[i];
      sum8_r <= SQW'(sq7_r[0]) + SQW'(sq7_r[1]) + SQW'(sq7_r[2]);
    end
  end

  logic [LENW-1:0] len;

  tnac_sqrt #(.IN_W(SQW)) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .din  (sum8_r),
    .root (len)
  );

  logic [3*MANT+KW-1:0] sk_d;
  logic [MANT-1:0]      s_d [3];
  logic [KW-1:0]        k_d;

  tnac_delay #(.WIDTH(3*MANT+KW), .DEPTH(T_LEN - T_S)) u_dly_sk (
    .clk  (clk),
    .en   (adv),
    .din  ({k6_r, s6_r[2], s6_r[1], s6_r[0]}),
    .dout (sk_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) s_d[i] = sk_d[i*MANT +: MANT];
    k_d = sk_d[3*MANT +: KW];
  end

  // Divider setup, area and zero test
  logic [KW-1:0]   lsh;
  logic [KW-1:0]   rsh;
  logic [AB-1:0]   area_nxt;
  logic [NUMW-1:0] num_r [3];
  logic [DENW-1:0] den_r;
  logic [AB-1:0]   area_r;
  logic            dgn_r;

  assign lsh = k_d - KW'(FRAC_BITS + 1);
  assign rsh = KW'(FRAC_BITS + 1) - k_d;

  always_comb begin
    if (k_d >= KW'(FRAC_BITS + 1)) begin
      if (lsh >= KW'(AB) || AB'(len) > (AREA_MAX >> lsh)) begin
        area_nxt = AREA_MAX;
      end else begin
        area_nxt = AB'(len) << lsh;
      end
    end else begin
      area_nxt = AB'(len >> rsh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUMW'(s_d[i]) << UQW) + NUMW'(len);
      end
      den_r  <= {len, 1'b0};
      area_r <= area_nxt;
      dgn_r  <= (len == '0);
    end
  end

  logic [UQW-1:0] uq [3];

  for (genvar g = 0; g < 3; g++) begin : g_udiv
    tnac_div #(.NUM_W(NUMW), .DEN_W(DENW), .Q_W(UQW)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num_r[g]),
      .den (den_r),
      .quo (uq[g])
    );
  end

  // Centroid: (|sum|+1)/3 by reciprocal multiplication
  logic [CQW-1:0] cq3_r [3];
  logic [CQW-1:0] cq    [3];
  logic [2:0]     cs_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cq3_r[i] <= CQW'((QPW'(cm2_r[i]) * QPW'(TRCP)) >> TSH);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_cdly
    tnac_delay #(.WIDTH(CQW), .DEPTH(T_Q - T_DIF - 1)) u_dly_cq (
      .clk  (clk),
      .en   (adv),
      .din  (cq3_r[g]),
      .dout (cq[g])
    );
  end

  tnac_delay #(.WIDTH(3), .DEPTH(T_Q - T_DIF)) u_dly_cs (
    .clk  (clk),
    .en   (adv),
    .din  ({cs2_r[2], cs2_r[1], cs2_r[0]}),
    .dout (cs_d)
  );

  logic [TAGW-1:0] tag_d;
  logic [2:0]      ng_d;
  logic [AB:0]     ad_d;

  tnac_delay #(.WIDTH(TAGW), .DEPTH(T_Q - T_IN)) u_dly_tag (
    .clk  (clk),
    .en   (adv),
    .din  (tag1_r),
    .dout (tag_d)
  );

  tnac_delay #(.WIDTH(3), .DEPTH(T_Q - T_S)) u_dly_ng (
    .clk  (clk),
    .en   (adv),
    .din  ({ng6_r[2], ng6_r[1], ng6_r[0]}),
    .dout (ng_d)
  );

  tnac_delay #(.WIDTH(AB+1), .DEPTH(T_Q - T_SET)) u_dly_area (
    .clk  (clk),
    .en   (adv),
    .din  ({dgn_r, area_r}),
    .dout (ad_d)
  );

  // Output register
  logic [TAGW-1:0] tag_o_r;
  logic [UB-1:0]   unit_r [3];
  logic [AB-1:0]   area_o_r;
  logic [C-1:0]    mid_r  [3];
  logic            dgn_o_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_o_r  <= tag_d;
      dgn_o_r  <= ad_d[AB];
      area_o_r <= ad_d[AB] ? '0 : ad_d[AB-1:0];
      for (int i = 0; i < 3; i++) begin
        if (ad_d[AB]) begin
          unit_r[i] <= '0;
        end else begin
          unit_r[i] <= ng_d[i] ? UB'(0) - UB'(uq[i]) : UB'(uq[i]);
        end
        mid_r[i] <= C'(cs_d[i] ? CQW'(0) - cq[i] : cq[i]);
      end
    end
  end

  assign out_tvalid = vld_r[T_OUT-1];
  assign out_tuser  = dgn_o_r;
  assign out_tdata  = OUT_TDW'({mid_r[2], mid_r[1], mid_r[0], area_o_r,
                                unit_r[2], unit_r[1], unit_r[0], tag_o_r});

  // Checks
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !adv |=> skid_v_r && $stable(skid_r))
    else $error("skid entry lost while pipe stalled");

  a_dgn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dgn_o_r |-> unit_r[0] == '0 && unit_r[1] == '0
                              && unit_r[2] == '0 && area_o_r == '0)
    else $error("degenerate face with non-zero normal or area");

  a_unit_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !dgn_o_r |-> (unit_r[0] | unit_r[1] | unit_r[2]) != '0)
    else $error("zero normal on non-degenerate face");

endmodule
`default_nettype wire

// ----- tb/sv/tb_triangle_normal_area_centroid.sv -----
// Self-checking testbench for triangle_normal_area_centroid: drives triangles, predicts
// the unit normal, area, centroid and degenerate flag, and compares every result.
// Depends on tnac_pkg and the RTL top level only.
`timescale 1ns / 100ps
module tb_triangle_normal_area_centroid;

  localparam int TAG_BITS  = tnac_pkg::TAG_BITS;
  localparam int UNIT_FRAC = tnac_pkg::UNIT_FRAC;
  localparam int UNIT_BITS = tnac_pkg::UNIT_BITS;
  localparam int AREA_BITS = tnac_pkg::AREA_BITS;
  localparam int MANT_BITS = tnac_pkg::MANT_BITS;
  localparam int CB        = tnac_pkg::COORD_BITS_DEF;
  localparam int IN_TDW  = ((TAG_BITS + 9 * CB + 7) / 8) * 8;
  localparam int OUT_TDW = ((TAG_BITS + 3 * UNIT_BITS + AREA_BITS + 3 * CB + 7) / 8) * 8;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam logic [63:0] AREA_MAX = (64'd1 << AREA_BITS) - 1;

  typedef struct {
    logic [TAG_BITS-1:0]  tag;
    logic signed [CB-1:0] crd [9];  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
  } tri_t;

  typedef struct {
    logic [TAG_BITS-1:0]  tag;
    logic [UNIT_BITS-1:0] unit [3];
    logic [AREA_BITS-1:0] area;
    logic [CB-1:0]        mid [3];
    logic                 degen;
  } face_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDW-1:0] out_tdata;
  logic out_tuser;

  triangle_normal_area_centroid u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  tri_t  tri_queue [$];
  face_t face_expected [$];
  bit    keep_winding = 1'b0;
  bit    idle_on = 1'b1;
  bit    in_taken = 1'b0;
  int    in_gap = 0;
  int    out_gap = 0;
  int    n_fail = 0;
  int    quiet_cycles = 0;

  function automatic logic [IN_TDW-1:0] pack_tri(tri_t t);
    logic [IN_TDW-1:0] d;
    d = '0;
    d[TAG_BITS-1:0] = t.tag;
    for (int i = 0; i < 9; i++) d[TAG_BITS + i*CB +: CB] = t.crd[i];
    return d;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic face_t face_of(logic [IN_TDW-1:0] d, bit keep);
    face_t f;
    longint a [3], b [3], c [3];
    logic signed [127:0] u [3], v [3], n [3];
    logic [127:0] mag [3], any;
    bit neg [3];
    logic [63:0] s [3], sum, len, q, sm;
    longint tot;
    int bl, k, e;
    sum = 0;
    any = 0;
    bl = 0;
    f.tag = d[TAG_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(d[TAG_BITS + i*CB +: CB]));
      b[i] = longint'($signed(d[TAG_BITS + (keep ? 3 + i : 6 + i)*CB +: CB]));
      c[i] = longint'($signed(d[TAG_BITS + (keep ? 6 + i : 3 + i)*CB +: CB]));
      u[i] = b[i] - a[i];
      v[i] = c[i] - a[i];
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i] < 0;
      mag[i] = neg[i] ? -n[i] : n[i];
      any |= mag[i];
    end
    for (int i = 127; i >= 0; i--)
      if (any[i] && bl == 0) bl = i + 1;
    k = (bl > MANT_BITS) ? bl - MANT_BITS : 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = 64'(mag[i] >> k);
      sum += s[i] * s[i];
    end
    len = isqrt(sum);
    if (len == 0) begin
      for (int i = 0; i < 3; i++) f.unit[i] = '0;
      f.area = '0;
      f.degen = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        q = ((s[i] << (UNIT_FRAC + 1)) + len) / (2 * len);
        if (neg[i]) q = -q;
        f.unit[i] = q[UNIT_BITS-1:0];
      end
      e = k - (tnac_pkg::FRAC_BITS_DEF + 1);
      if (e < 0) f.area = AREA_BITS'(len >> (-e));
      else if (e >= AREA_BITS || len > (AREA_MAX >> e)) f.area = AREA_BITS'(AREA_MAX);
      else f.area = AREA_BITS'(len << e);
      f.degen = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      tot = a[i] + b[i] + c[i];
      sm = ((tot < 0 ? -tot : tot) + 1) / 3;
      if (tot < 0) sm = -sm;
      f.mid[i] = sm[CB-1:0];
    end
    return f;
  endfunction

  function automatic logic signed [CB-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return 1;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    logic signed [CB-1:0] d;
    int mode;
    t.tag = TAG_BITS'($urandom);
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) t.crd[i] = $urandom;
    for (int i = 3; i < 9; i++) begin
      case (mode)
        0, 1, 2, 3: t.crd[i] = $urandom;
        4, 5, 6:    t.crd[i] = t.crd[i % 3] + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
        7:          t.crd[i] = edge_coord();
        default:    t.crd[i] = t.crd[i % 3] + $signed(32'($urandom_range(0, 8)) - 4);
      endcase
    end
    if (mode == 8) begin
      // collinear or repeated vertices
      for (int i = 0; i < 3; i++) begin
        d = $signed(32'($urandom_range(0, 1 << 16)) - (1 << 15));
        if ($urandom_range(0, 1)) d = 0;
        t.crd[i] = $signed(32'($urandom_range(0, 1 << 30)) - (1 << 29));
        t.crd[3 + i] = t.crd[i] + d;
        t.crd[6 + i] = t.crd[i] + 2 * d;
      end
    end
    if (mode == 7) for (int i = 0; i < 3; i++) t.crd[i] = edge_coord();
    return t;
  endfunction

  function automatic tri_t make_tri(logic [15:0] tag, logic signed [CB-1:0] ax, ay, az,
                                    bx, by, bz, cx, cy, cz);
    tri_t t;
    t.tag = tag;
    t.crd = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return t;
  endfunction

  task automatic add_tri(tri_t t);
    tri_queue = {tri_queue, t};
  endtask

  task automatic queue_directed();
    logic signed [CB-1:0] mn, mx, one;
    mn = {1'b1, {(CB-1){1'b0}}};
    mx = {1'b0, {(CB-1){1'b1}}};
    one = 32'sh0001_0000;
    add_tri(make_tri(16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_tri(make_tri(16'hFFFF, 0, 0, 0, one, 0, 0, 0, one, 0));
    add_tri(make_tri(16'h0001, 0, 0, 0, 0, one, 0, one, 0, 0));
    add_tri(make_tri(16'h8000, 0, 0, 0, 0, 0, one, one, 0, 0));
    add_tri(make_tri(16'h7FFF, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    add_tri(make_tri(16'h1234, mn, mn, 0, mx, mn, 0, mn, mx, 0));
    add_tri(make_tri(16'h2345, mn, mn, mn, mx, mn, mx, mn, mx, mx));
    add_tri(make_tri(16'h3456, mx, mx, mx, mn, mx, mn, mx, mn, mn));
    add_tri(make_tri(16'h4567, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    add_tri(make_tri(16'h5678, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    add_tri(make_tri(16'h6789, one, one, one, 2*one, 2*one, 2*one,
                     3*one, 3*one, 3*one));
    add_tri(make_tri(16'h789A, mx, 0, 0, 0, mx, 0, 0, 0, mx));
    add_tri(make_tri(16'h89AB, mn, 0, 0, 0, mn, 0, 0, 0, mn));
    add_tri(make_tri(16'h9ABC, -1, -1, -1, 1, -1, 2, -1, 1, -2));
    add_tri(make_tri(16'hABCD, 1, 2, 0, -1, 0, 0, 0, 0, 1));
    add_tri(make_tri(16'hBCDE, mx, mn, mx, mn, mx, mn, 0, 0, 0));
    add_tri(make_tri(16'hCDEF, -one, -one, 0, one, -one, 0, 0, one, one));
    add_tri(make_tri(16'h5555, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh3333_3333));
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) add_tri(rand_tri());
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (tri_queue.size() != 0 || in_tvalid || face_expected.size() != 0);
  endtask

  task automatic write_winding(bit keep);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= keep;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    keep_winding = keep;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      n_fail++;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    logic nxt_valid;
    logic [IN_TDW-1:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data = in_tdata;
    if (rst_n && (!in_tvalid || in_taken)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 9) - 1;
      end else if (tri_queue.size() != 0) begin
        nxt_data = pack_tri(tri_queue.pop_front());
        nxt_valid = 1'b1;
      end
    end
    in_taken = 1'b0;
    in_tvalid <= nxt_valid;
    in_tdata <= nxt_data;
  end

  // result back-pressure
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 9) - 1;
      nxt_ready = 1'b0;
    end
    out_tready <= nxt_ready;
  end

  // monitor
  always @(posedge clk) begin
    face_t f;
    if (rst_n) begin
      quiet_cycles++;
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        face_expected = {face_expected, face_of(in_tdata, keep_winding)};
        quiet_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        if (face_expected.size() == 0) begin
          $error("unexpected result transaction");
          n_fail++;
        end else begin
          f = face_expected.pop_front();
          check_field("out_tag", f.tag, out_tdata[15:0]);
          check_field("unit_x", f.unit[0], out_tdata[16 +: UNIT_BITS]);
          check_field("unit_y", f.unit[1], out_tdata[16 + UNIT_BITS +: UNIT_BITS]);
          check_field("unit_z", f.unit[2], out_tdata[16 + 2*UNIT_BITS +: UNIT_BITS]);
          check_field("tri_area", f.area, out_tdata[16 + 3*UNIT_BITS +: AREA_BITS]);
          for (int i = 0; i < 3; i++)
            check_field($sformatf("mid_%s", i == 0 ? "x" : i == 1 ? "y" : "z"), f.mid[i],
                        out_tdata[16 + 3*UNIT_BITS + AREA_BITS + i*CB +: CB]);
          check_field("degenerate", f.degen, out_tuser);
        end
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    queue_random(200);
    wait_drained();

    write_winding(1'b1);
    queue_directed();
    queue_random(250);
    wait_drained();

    write_winding(1'b0);
    queue_random(200);
    wait_drained();

    write_winding(1'b1);
    idle_on = 1'b0;
    queue_random(200);
    wait_drained();

    repeat (80) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- triangle_normal_area_centroid.f -----
rtl/tnac_pkg.sv
rtl/tnac_delay.sv
rtl/tnac_sqrt.sv
rtl/tnac_div.sv
rtl/triangle_normal_area_centroid.sv
tb/sv/tb_triangle_normal_area_centroid.sv
